>>> sv/primitive_triangulator_macros.svh
// ----------------------------------------------------------------------------
// Primitive triangulator assertion macros
// Shorthand for clocked checks, all disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PRIMITIVE_TRIANGULATOR_MACROS_SVH
`define PRIMITIVE_TRIANGULATOR_MACROS_SVH

// Check that cond holds at every clock edge outside reset.
`define PTRI_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that cons holds at every edge where ante holds.
`define PTRI_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> sv/ptri_pkg.sv
// ----------------------------------------------------------------------------
// Primitive triangulator package
// Beat types, mode and error codes, and the job record shared by the stages.
// ----------------------------------------------------------------------------
package ptri_pkg;

    localparam int HANDLE_PORT_BITS     = 32;
    localparam int HANDLE_BITS_DEFAULT  = 32;
    localparam int MODE_BITS            = 3;
    localparam int IDX_BITS             = 3;

    typedef logic [MODE_BITS-1:0] mode_t;

    localparam mode_t MODE_TRIANGLES = 3'd2;
    localparam mode_t MODE_QUADS     = 3'd3;
    localparam mode_t MODE_POLYGON   = 3'd4;

    localparam logic [IDX_BITS-1:0] QUAD_LAST_IDX = 3'd5;
    localparam logic [IDX_BITS-1:0] POLY_LAST_IDX = 3'd2;
    localparam logic [IDX_BITS-1:0] ONE_LAST_IDX  = 3'd0;

    typedef enum logic [1:0] {
        ERR_NONE          = 2'd0,
        ERR_PARTIAL_QUAD  = 2'd1,
        ERR_SHORT_POLYGON = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        JOB_PASS,
        JOB_QUAD,
        JOB_POLY,
        JOB_ERR_QUAD,
        JOB_ERR_POLY
    } job_kind_t;

    typedef struct packed {
        logic [HANDLE_PORT_BITS-1:0] vertex_handle;
        logic                        batch_last;
    } vertex_t;

    typedef struct packed {
        logic [HANDLE_PORT_BITS-1:0] out_vertex;
        logic                        run_last;
        logic                        batch_end;
        err_t                        error_code;
    } result_t;

    typedef struct packed {
        job_kind_t                   kind;
        logic [HANDLE_PORT_BITS-1:0] h_first;
        logic [HANDLE_PORT_BITS-1:0] h_second;
        logic [HANDLE_PORT_BITS-1:0] h_third;
        logic [HANDLE_PORT_BITS-1:0] h_cur;
        logic                        batch_last;
    } job_t;

    typedef struct packed {
        logic busy;
        logic finishing;
    } emit_status_t;

endpackage

>>> sv/ptri_assembler.sv
// ----------------------------------------------------------------------------
// Primitive triangulator assembler
// Holds mode, vertex count and slots; turns each accepted vertex that completes a primitive or an error into a job.
// ----------------------------------------------------------------------------
module ptri_assembler #(
    parameter int HANDLE_BITS = ptri_pkg::HANDLE_BITS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  ptri_pkg::mode_t  cfg_data,
    input  logic             vertex_fire,
    input  ptri_pkg::vertex_t vertex,
    output logic             job_valid,
    output ptri_pkg::job_t   job
);
    import ptri_pkg::*;

    localparam int SLOT_BITS =
        (HANDLE_BITS < HANDLE_PORT_BITS) ? HANDLE_BITS : HANDLE_PORT_BITS;

    mode_t                mode_reg, mode_next;
    logic [1:0]           count_reg, count_next;
    logic [SLOT_BITS-1:0] first_reg, first_next;
    logic [SLOT_BITS-1:0] second_reg, second_next;
    logic [SLOT_BITS-1:0] third_reg, third_next;
    logic [SLOT_BITS-1:0] h;
    logic                 last;

    assign cfg_ready = 1'b1;
    assign h         = vertex.vertex_handle[SLOT_BITS-1:0];
    assign last      = vertex.batch_last;

    always_comb
    begin
        job.kind       = JOB_PASS;
        job.h_first    = HANDLE_PORT_BITS'(first_reg);
        job.h_second   = HANDLE_PORT_BITS'(second_reg);
        job.h_third    = HANDLE_PORT_BITS'(third_reg);
        job.h_cur      = HANDLE_PORT_BITS'(h);
        job.batch_last = last;
        job_valid      = 1'b1;
        count_next     = 2'd0;
        first_next     = first_reg;
        second_next    = second_reg;
        third_next     = third_reg;

        if (mode_reg == MODE_QUADS)
        begin
            if (count_reg == 2'd3)
            begin
                job.kind = JOB_QUAD;
            end
            else if (last)
            begin
                job.kind = JOB_ERR_QUAD;
            end
            else
            begin
                // collect the next corner, no result yet
                job_valid = 1'b0;
                case (count_reg)
                    2'd0:    first_next  = h;
                    2'd1:    second_next = h;
                    default: third_next  = h;
                endcase
                count_next = count_reg + 2'd1;
            end
        end
        else if (mode_reg == MODE_POLYGON)
        begin
            if (count_reg >= 2'd2)
            begin
                job.kind    = JOB_POLY;
                second_next = h;
                count_next  = last ? 2'd0 : 2'd2;
            end
            else if (last)
            begin
                job.kind = JOB_ERR_POLY;
            end
            else
            begin
                job_valid = 1'b0;
                if (count_reg == 2'd0)
                    first_next = h;
                else
                    second_next = h;
                count_next = count_reg + 2'd1;
            end
        end

        mode_next = mode_reg;
        if (cfg_valid)
        begin
            mode_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_TRIANGLES;
            count_reg <= 2'd0;
        end
        else
        begin
            mode_reg <= mode_next;
            // a mode write starts a new batch
            if (cfg_valid)
                count_reg <= 2'd0;
            else if (vertex_fire)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vertex_fire)
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
            third_reg  <= third_next;
        end
    end

endmodule

>>> sv/ptri_emitter.sv
// ----------------------------------------------------------------------------
// Primitive triangulator emitter
// Holds one job and steps out its results, one beat a cycle unless the output stalls, into the output register.
// ----------------------------------------------------------------------------
module ptri_emitter (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   job_load,
    input  ptri_pkg::job_t         job_in,
    output ptri_pkg::emit_status_t status,
    output logic                   result_valid,
    input  logic                   result_ready,
    output ptri_pkg::result_t      result_data
);
    import ptri_pkg::*;

    job_t                job_reg, job_next;
    logic                job_valid_reg, job_valid_next;
    logic [IDX_BITS-1:0] idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;
    logic [IDX_BITS-1:0] idx_last;
    result_t             cur;
    logic                out_load;
    logic                job_ready;

    always_comb
    begin
        case (job_reg.kind)
            JOB_QUAD: idx_last = QUAD_LAST_IDX;
            JOB_POLY: idx_last = POLY_LAST_IDX;
            default:  idx_last = ONE_LAST_IDX;
        endcase

        cur.out_vertex = job_reg.h_cur;
        cur.run_last   = (idx_reg == idx_last);
        cur.batch_end  = (idx_reg == idx_last) && job_reg.batch_last;
        cur.error_code = ERR_NONE;
        case (job_reg.kind)
            JOB_QUAD:
            begin
                // v1 v2 v3 v3 v4 v1
                case (idx_reg)
                    3'd0:    cur.out_vertex = job_reg.h_first;
                    3'd1:    cur.out_vertex = job_reg.h_second;
                    3'd2:    cur.out_vertex = job_reg.h_third;
                    3'd3:    cur.out_vertex = job_reg.h_third;
                    3'd4:    cur.out_vertex = job_reg.h_cur;
                    default: cur.out_vertex = job_reg.h_first;
                endcase
            end
            JOB_POLY:
            begin
                case (idx_reg)
                    3'd0:    cur.out_vertex = job_reg.h_first;
                    3'd1:    cur.out_vertex = job_reg.h_second;
                    default: cur.out_vertex = job_reg.h_cur;
                endcase
            end
            JOB_ERR_QUAD:
            begin
                cur.out_vertex = '0;
                cur.batch_end  = 1'b1;
                cur.error_code = ERR_PARTIAL_QUAD;
            end
            JOB_ERR_POLY:
            begin
                cur.out_vertex = '0;
                cur.batch_end  = 1'b1;
                cur.error_code = ERR_SHORT_POLYGON;
            end
            default:
            begin
                cur.out_vertex = job_reg.h_cur;
            end
        endcase

        out_load         = job_valid_reg && (!out_valid_reg || result_ready);
        status.busy      = job_valid_reg;
        status.finishing = out_load && (idx_reg == idx_last);
        job_ready        = !job_valid_reg || status.finishing;

        job_valid_next = job_ready ? job_load : job_valid_reg;
        job_next       = (job_ready && job_load) ? job_in : job_reg;
        if (job_ready)
            idx_next = '0;
        else if (out_load)
            idx_next = idx_reg + 3'd1;
        else
            idx_next = idx_reg;

        if (out_load)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
        out_next = out_load ? cur : out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

endmodule

>>> sv/primitive_triangulator.sv
// ----------------------------------------------------------------------------
// Primitive triangulator
// Assembles a stream of vertex handles into points, lines, triangles, quads
// split into two triangles, or polygon fans.
// ----------------------------------------------------------------------------
// Usage:
//   vertex channel  (vertex_valid/ready/data): one handle per beat, batch_last
//                   marks the final vertex of a batch.
//   result channel  (result_valid/ready/data): one emitted vertex per beat;
//                   an error beat (zero vertex, error_code set) closes a
//                   malformed batch, and the receiver drops that batch.
//   cfg channel     (cfg_valid/ready/data): prim_mode; write only while idle.
//                   A write also restarts batch assembly.
// Path: the first result of a vertex is registered in the job register and then
//   in the output register before it reaches the result port.
// Throughput: the output register moves one result per cycle while result_ready
//   is high, so pass-through modes then take a vertex every cycle and each
//   polygon vertex past the second yields three results. A quad yields six
//   results, while the gathering vertices of the next quad wait for the job register.
// Reset: mode returns to triangles, the vertex count and both beat buffers
//   clear; no clearing pass is needed.
// Stall: when result_ready is low the output beat holds, the job register
//   holds its remaining results, and vertex_ready drops once the job register
//   cannot hand over.
// ----------------------------------------------------------------------------
`include "primitive_triangulator_macros.svh"

module primitive_triangulator #(
    parameter int HANDLE_BITS = ptri_pkg::HANDLE_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  ptri_pkg::mode_t    cfg_data,
    input  logic               vertex_valid,
    output logic               vertex_ready,
    input  ptri_pkg::vertex_t  vertex_data,
    output logic               result_valid,
    input  logic               result_ready,
    output ptri_pkg::result_t  result_data
);
    import ptri_pkg::*;

    logic         vertex_fire;
    logic         job_valid;
    job_t         job;
    emit_status_t status;
    logic         cfg_fire;

    // Accept a vertex whenever the job register is empty or hands over now.
    assign vertex_ready = !status.busy || status.finishing;
    assign vertex_fire  = vertex_valid && vertex_ready;
    assign cfg_fire     = cfg_valid && cfg_ready;

    ptri_assembler #(
        .HANDLE_BITS (HANDLE_BITS)
    ) u_assembler (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_fire),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .vertex_fire (vertex_fire),
        .vertex      (vertex_data),
        .job_valid   (job_valid),
        .job         (job)
    );

    // Load a job only for vertices that cause results.
    ptri_emitter u_emitter (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_load     (vertex_fire && job_valid),
        .job_in       (job),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    `PTRI_ASSERT_IMPLIES(a_error_beat_shape,
        result_valid && (result_data.error_code != ERR_NONE),
        (result_data.out_vertex == '0) && result_data.run_last && result_data.batch_end,
        "error beat must be zero vertex closing its batch")
    `PTRI_ASSERT_HOLDS(a_batch_end_run_last,
        !(result_valid && result_data.batch_end && !result_data.run_last),
        "batch end without run end")
    `PTRI_ASSERT_IMPLIES(a_accept_only_on_handover,
        vertex_fire && status.busy, status.finishing,
        "vertex accepted while job still emitting")

endmodule
